[hw/rtl/kmer_indexed_accumulator_table_top_macros.svh]
// Assertion macros used by the k-mer table port-level checker.
`ifndef KMER_INDEXED_ACCUMULATOR_TABLE_TOP_MACROS_SVH
`define KMER_INDEXED_ACCUMULATOR_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KIAT_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kiat check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KIAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kiat check failed");

`endif

[hw/rtl/kiat_pkg.sv]
// Shared types, codes and constants of the k-mer accumulator table.
package kiat_pkg;

	localparam int KMER_DEFAULT       = 5;
	localparam int VALUE_BITS_DEFAULT = 32;

	localparam int KEY_W        = 40;
	localparam int POS_W        = 3;
	localparam int AMOUNT_W     = 32;
	localparam int SLOT_FIELD_W = 3;
	localparam int SLOT_VALUE_W = 32;
	localparam int CHAR_W       = 8;

	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_U = 8'h55;

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_U = 2'd3;

	typedef enum logic {
		ACTION_ADD  = 1'b0,
		ACTION_READ = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_UNWRITTEN = 2'd1,
		STATUS_BAD_KEY   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_STREAM
	} state_t;

	typedef struct packed {
		action_t                     action;
		logic [KEY_W-1:0]            key_chars;
		logic [POS_W-1:0]            position;
		logic signed [AMOUNT_W-1:0]  add_value;
	} req_beat_t;

	typedef struct packed {
		status_t                        status;
		logic [SLOT_FIELD_W-1:0]        slot;
		logic signed [SLOT_VALUE_W-1:0] slot_value;
		logic                           last;
	} rsp_beat_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic emit;
		logic update;
		logic advance;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_free;
		logic bad_key;
		logic is_read;
		logic entry_hit;
		logic slot_last;
	} dp_status_t;

endpackage

[hw/rtl/kiat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kiat_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/kiat_ctrl.sv]
// Controller state machine: clearing sweep, accept, update and slot streaming.
module kiat_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  kiat_pkg::dp_status_t   stat,
	output kiat_pkg::ctrl_cmd_t    cmd
);

	kiat_pkg::state_t state_q;
	kiat_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kiat_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kiat_pkg::ST_CLEAR: begin
				if (stat.clear_done) begin
					state_d = kiat_pkg::ST_IDLE;
				end
			end
			kiat_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = kiat_pkg::ST_EXEC;
				end
			end
			kiat_pkg::ST_EXEC: begin
				if (stat.out_free) begin
					if (!stat.bad_key && stat.is_read && stat.entry_hit) begin
						state_d = kiat_pkg::ST_STREAM;
					end else begin
						state_d = kiat_pkg::ST_IDLE;
					end
				end
			end
			kiat_pkg::ST_STREAM: begin
				if (stat.out_free && stat.slot_last) begin
					state_d = kiat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kiat_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			kiat_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			kiat_pkg::ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			kiat_pkg::ST_EXEC: begin
				cmd.emit    = stat.out_free;
				cmd.update  = stat.out_free && !stat.bad_key && !stat.is_read;
				cmd.advance = stat.out_free && !stat.bad_key && stat.is_read
					&& stat.entry_hit;
			end
			kiat_pkg::ST_STREAM: begin
				cmd.emit    = stat.out_free;
				cmd.advance = stat.out_free && !stat.slot_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hw/rtl/kiat_dp.sv]
// Datapath: key coding, table memories, saturating add and result register.
module kiat_dp #(
	parameter int KMER       = kiat_pkg::KMER_DEFAULT,
	parameter int VALUE_BITS = kiat_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kiat_pkg::req_beat_t   req,
	input  kiat_pkg::ctrl_cmd_t   cmd,
	output kiat_pkg::dp_status_t  stat,
	output kiat_pkg::rsp_beat_t   rsp,
	output logic                  rsp_valid,
	input  logic                  rsp_stall
);

	localparam int SLOTS     = KMER + 1;
	localparam int IDX_W     = 2 * KMER;
	localparam int ENTRIES   = 1 << IDX_W;
	localparam int ACC_DEPTH = ENTRIES * SLOTS;
	localparam int ACC_AW    = $clog2(ACC_DEPTH);
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int SUM_W     = ((VALUE_BITS > kiat_pkg::AMOUNT_W) ?
		VALUE_BITS : kiat_pkg::AMOUNT_W) + 1;
	localparam int KEY_PAD_W = (kiat_pkg::CHAR_W * KMER > kiat_pkg::KEY_W) ?
		kiat_pkg::CHAR_W * KMER : kiat_pkg::KEY_W;
	localparam logic signed [SUM_W-1:0] SAT_MAX =
		$signed({{(SUM_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}});
	localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

	logic [KEY_PAD_W-1:0]              key_pad;
	logic [kiat_pkg::CHAR_W-1:0]       ch;
	logic [IDX_W-1:0]                  idx_c;
	logic                              bad_c;
	logic                              pos_ok_c;
	logic [ACC_AW-1:0]                 addr_c;

	logic [IDX_W-1:0]                  idx_q;
	logic                              bad_q;
	logic                              read_q;
	logic                              pos_ok_q;
	logic [kiat_pkg::POS_W-1:0]        pos_q;
	logic signed [kiat_pkg::AMOUNT_W-1:0] amount_q;
	logic [ACC_AW-1:0]                 acc_addr_q;
	logic [SLOT_W-1:0]                 slot_q;
	logic [ACC_AW-1:0]                 clr_q;
	kiat_pkg::rsp_beat_t               rsp_q;
	logic                              rsp_valid_q;

	logic                              acc_we;
	logic [ACC_AW-1:0]                 acc_waddr;
	logic [VALUE_BITS-1:0]             acc_wdata;
	logic                              acc_re;
	logic [ACC_AW-1:0]                 acc_raddr;
	logic [VALUE_BITS-1:0]             acc_rdata;

	logic                              val_we;
	logic [IDX_W-1:0]                  val_waddr;
	logic [0:0]                        val_wdata;
	logic [0:0]                        val_rdata;

	logic signed [SUM_W-1:0]           acc_x;
	logic signed [SUM_W-1:0]           sum;
	logic [VALUE_BITS-1:0]             sat_value;
	logic                              slot_last;
	logic                              out_free;
	kiat_pkg::rsp_beat_t               rsp_d;

	assign key_pad = KEY_PAD_W'(req.key_chars);

	always_comb begin
		ch    = '0;
		idx_c = '0;
		bad_c = 1'b0;
		for (int i = 0; i < KMER; i++) begin
			ch = key_pad[(KMER - 1 - i) * kiat_pkg::CHAR_W +: kiat_pkg::CHAR_W];
			unique case (ch)
				kiat_pkg::CHAR_A: idx_c[(KMER - 1 - i) * 2 +: 2] = kiat_pkg::CODE_A;
				kiat_pkg::CHAR_C: idx_c[(KMER - 1 - i) * 2 +: 2] = kiat_pkg::CODE_C;
				kiat_pkg::CHAR_G: idx_c[(KMER - 1 - i) * 2 +: 2] = kiat_pkg::CODE_G;
				kiat_pkg::CHAR_U: idx_c[(KMER - 1 - i) * 2 +: 2] = kiat_pkg::CODE_U;
				default:          bad_c = 1'b1;
			endcase
		end
	end

	assign pos_ok_c = int'(req.position) <= KMER;

	always_comb begin
		addr_c = ACC_AW'(idx_c * SLOTS);
		if (req.action == kiat_pkg::ACTION_ADD && pos_ok_c) begin
			addr_c = addr_c + ACC_AW'(req.position);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q    <= idx_c;
			bad_q    <= bad_c;
			read_q   <= req.action == kiat_pkg::ACTION_READ;
			pos_ok_q <= pos_ok_c;
			pos_q    <= req.position;
			amount_q <= req.add_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_addr_q  <= '0;
			slot_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + ACC_AW'(1);
			end
			if (cmd.capture) begin
				acc_addr_q <= addr_c;
				slot_q     <= '0;
			end else if (cmd.advance) begin
				acc_addr_q <= acc_addr_q + ACC_AW'(1);
				slot_q     <= slot_q + SLOT_W'(1);
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign acc_we    = cmd.clear || (cmd.update && pos_ok_q);
	assign acc_waddr = cmd.clear ? clr_q : acc_addr_q;
	assign acc_wdata = cmd.clear ? '0 : sat_value;
	assign acc_re    = cmd.capture || cmd.advance;
	assign acc_raddr = cmd.capture ? addr_c : acc_addr_q + ACC_AW'(1);

	assign val_we    = (cmd.clear && int'(clr_q) < ENTRIES) || (cmd.update && pos_ok_q);
	assign val_waddr = cmd.clear ? clr_q[IDX_W-1:0] : idx_q;
	assign val_wdata = cmd.clear ? 1'b0 : 1'b1;

	kiat_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (ACC_DEPTH)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.re    (acc_re),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	kiat_ram #(
		.WIDTH (1),
		.DEPTH (ENTRIES)
	) u_valid_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.re    (cmd.capture),
		.raddr (idx_c),
		.rdata (val_rdata)
	);

	assign acc_x = SUM_W'($signed(acc_rdata));
	assign sum   = acc_x + SUM_W'(amount_q);

	always_comb begin
		if (sum > SAT_MAX) begin
			sat_value = SAT_MAX[VALUE_BITS-1:0];
		end else if (sum < SAT_MIN) begin
			sat_value = SAT_MIN[VALUE_BITS-1:0];
		end else begin
			sat_value = sum[VALUE_BITS-1:0];
		end
	end

	assign slot_last = slot_q == SLOT_W'(KMER);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		rsp_d        = '0;
		rsp_d.status = kiat_pkg::STATUS_OK;
		rsp_d.last   = 1'b1;
		priority if (bad_q) begin
			rsp_d.status = kiat_pkg::STATUS_BAD_KEY;
		end else if (!read_q) begin
			rsp_d.slot = pos_q;
		end else if (!val_rdata[0]) begin
			rsp_d.status = kiat_pkg::STATUS_UNWRITTEN;
		end else begin
			rsp_d.slot       = kiat_pkg::SLOT_FIELD_W'(slot_q);
			rsp_d.slot_value = acc_x[kiat_pkg::SLOT_VALUE_W-1:0];
			rsp_d.last       = slot_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign stat.clear_done = clr_q == ACC_AW'(ACC_DEPTH - 1);
	assign stat.out_free   = out_free;
	assign stat.bad_key    = bad_q;
	assign stat.is_read    = read_q;
	assign stat.entry_hit  = val_rdata[0];
	assign stat.slot_last  = slot_last;

endmodule

[hw/rtl/kmer_indexed_accumulator_table_top.sv]
// Top level of the k-mer indexed accumulator table.
// Add or rejected key: accepted in the idle state, then updated and answered in the
// exec state once the output is free; no new request is taken before then. Read of
// a written entry: one slot per cycle while the output is not stalled, from the
// single RAM read port, first beat registered in the exec state. After reset a sweep
// zeroes the accumulators and valid marks; req_stall stays high until it ends.
module kmer_indexed_accumulator_table_top #(
	parameter int KMER       = kiat_pkg::KMER_DEFAULT,
	parameter int VALUE_BITS = kiat_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kiat_pkg::req_beat_t  req,
	input  logic                 req_valid,
	output logic                 req_stall,
	output kiat_pkg::rsp_beat_t  rsp,
	output logic                 rsp_valid,
	input  logic                 rsp_stall
);

	kiat_pkg::ctrl_cmd_t  cmd;
	kiat_pkg::dp_status_t stat;

	kiat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	kiat_dp #(
		.KMER       (KMER),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

[hw/rtl/kiat_checker.sv]
// Port-level checker for the k-mer accumulator table, bound to the top level.
`include "kmer_indexed_accumulator_table_top_macros.svh"

module kiat_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input kiat_pkg::rsp_beat_t  rsp,
	input logic                 rsp_valid,
	input logic                 rsp_stall
);

	`KIAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`KIAT_ASSERT_IMPLIES(a_partial_ok, rsp_valid && !rsp.last, rsp.status == kiat_pkg::STATUS_OK)
	`KIAT_ASSERT_IMPLIES(a_error_single, rsp_valid && rsp.status != kiat_pkg::STATUS_OK, rsp.last && rsp.slot == '0 && rsp.slot_value == '0)
	`KIAT_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall)

endmodule

bind kmer_indexed_accumulator_table_top kiat_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp       (rsp),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall)
);

[dv/kmer_indexed_accumulator_table_checker.sv]
// Checker for the k-mer accumulator table: predicts every response beat and compares it.
`timescale 1ns / 100ps

module kmer_indexed_accumulator_table_checker
	import kiat_pkg::*;
#(
	parameter int KMER = KMER_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_beat_t req,
	input  logic      req_valid,
	input  logic      req_stall,
	input  rsp_beat_t rsp,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	output int        errors,
	output int        pending
);

	localparam int SLOTS   = KMER + 1;
	localparam int ENTRIES = 1 << (2 * KMER);
	localparam int IDX_W   = 2 * KMER;

	bit                     written [ENTRIES];
	bit signed [AMOUNT_W-1:0] acc   [ENTRIES][SLOTS];
	rsp_beat_t              due_beats [$];
	int                     fail_count = 0;
	int                     waiting = 0;

	assign errors  = fail_count;
	assign pending = waiting;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic rsp_beat_t beat_of(input status_t st, input int sl,
			input logic [SLOT_VALUE_W-1:0] val, input logic lst);
		rsp_beat_t b;
		b.status     = st;
		b.slot       = SLOT_FIELD_W'(sl);
		b.slot_value = val;
		b.last       = lst;
		return b;
	endfunction

	function automatic logic key_to_index(input logic [KEY_W-1:0] key,
			output logic [IDX_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		logic [1:0]        code;
		idx = '0;
		for (int i = 0; i < KMER; i++) begin
			c = key[(KMER-1-i)*CHAR_W +: CHAR_W];
			case (c)
				CHAR_A: code = CODE_A;
				CHAR_C: code = CODE_C;
				CHAR_G: code = CODE_G;
				CHAR_U: code = CODE_U;
				default: return 1'b0;
			endcase
			idx = {idx[IDX_W-3:0], code};
		end
		return 1'b1;
	endfunction

	function automatic logic signed [AMOUNT_W-1:0] sat_sum(
			input logic signed [AMOUNT_W-1:0] a, input logic signed [AMOUNT_W-1:0] b);
		logic signed [AMOUNT_W:0] s;
		s = {a[AMOUNT_W-1], a} + {b[AMOUNT_W-1], b};
		if (s[AMOUNT_W] != s[AMOUNT_W-1])
			return s[AMOUNT_W] ? {1'b1, {(AMOUNT_W-1){1'b0}}} : {1'b0, {(AMOUNT_W-1){1'b1}}};
		return s[AMOUNT_W-1:0];
	endfunction

	task automatic apply_access(input req_beat_t b);
		logic [IDX_W-1:0] idx;
		if (!key_to_index(b.key_chars, idx)) begin
			due_beats.push_back(beat_of(STATUS_BAD_KEY, 0, '0, 1'b1));
		end else if (b.action == ACTION_ADD) begin
			if (b.position <= KMER) begin
				acc[idx][b.position] = sat_sum(acc[idx][b.position], b.add_value);
				written[idx] = 1'b1;
			end
			due_beats.push_back(beat_of(STATUS_OK, b.position, '0, 1'b1));
		end else if (!written[idx]) begin
			due_beats.push_back(beat_of(STATUS_UNWRITTEN, 0, '0, 1'b1));
		end else begin
			for (int i = 0; i < SLOTS; i++)
				due_beats.push_back(beat_of(STATUS_OK, i, acc[idx][i], i == SLOTS - 1));
		end
	endtask

	always @(posedge clk) begin
		rsp_beat_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_beats.size() == 0) begin
					report_mismatch("unexpected beat, slot", 32'(rsp.slot), '0);
				end else begin
					want = due_beats.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.slot !== want.slot)
						report_mismatch("slot", 32'(rsp.slot), 32'(want.slot));
					if (rsp.slot_value !== want.slot_value)
						report_mismatch("slot_value", rsp.slot_value, want.slot_value);
					if (rsp.last !== want.last)
						report_mismatch("last", 32'(rsp.last), 32'(want.last));
				end
			end
			if (req_valid && !req_stall)
				apply_access(req);
			waiting <= due_beats.size();
		end
	end

endmodule

[dv/tb_kmer_indexed_accumulator_table_top.sv]
// Testbench top for the k-mer accumulator table: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_kmer_indexed_accumulator_table_top;
	import kiat_pkg::*;

	localparam int KMER        = KMER_DEFAULT;
	localparam int IDX_W       = 2 * KMER;
	localparam int RANDOM_BEATS = 500;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	req_beat_t req = '0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	rsp_beat_t rsp;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	logic      quiet = 1'b0;
	int        errors;
	int        pending;
	int        cycles = 0;
	int        sent = 0;
	logic [IDX_W-1:0] hot_keys [8];

	kmer_indexed_accumulator_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	kmer_indexed_accumulator_table_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(99) < 8);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [KEY_W-1:0] key_of(input logic [IDX_W-1:0] idx);
		logic [KEY_W-1:0] k;
		logic [CHAR_W-1:0] c;
		k = '0;
		for (int i = 0; i < KMER; i++) begin
			case (idx[(KMER-1-i)*2 +: 2])
				CODE_A: c = CHAR_A;
				CODE_C: c = CHAR_C;
				CODE_G: c = CHAR_G;
				default: c = CHAR_U;
			endcase
			k[(KMER-1-i)*CHAR_W +: CHAR_W] = c;
		end
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] spoil(input logic [KEY_W-1:0] key, input int at);
		logic [CHAR_W-1:0] c;
		do
			c = CHAR_W'($urandom_range(255));
		while (c == CHAR_A || c == CHAR_C || c == CHAR_G || c == CHAR_U);
		key[at*CHAR_W +: CHAR_W] = c;
		return key;
	endfunction

	function automatic logic signed [AMOUNT_W-1:0] pick_amount();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			1: return $signed(32'($urandom_range(65535))) * ($urandom_range(1) ? 1 : -1);
			default: return $signed(32'($urandom));
		endcase
	endfunction

	function automatic req_beat_t add_beat(input logic [KEY_W-1:0] key, input int pos,
			input logic signed [AMOUNT_W-1:0] amount);
		req_beat_t b;
		b.action    = ACTION_ADD;
		b.key_chars = key;
		b.position  = POS_W'(pos);
		b.add_value = amount;
		return b;
	endfunction

	function automatic req_beat_t read_beat(input logic [KEY_W-1:0] key);
		req_beat_t b;
		b.action    = ACTION_READ;
		b.key_chars = key;
		b.position  = POS_W'($urandom_range(7));
		b.add_value = $signed(32'($urandom));
		return b;
	endfunction

	task automatic send_beat(input req_beat_t b);
		if (!quiet && $urandom_range(99) < 8) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req       <= b;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [KEY_W-1:0] k;
		logic [IDX_W-1:0] idx;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_beat(read_beat(key_of(0)));
		send_beat(add_beat(key_of(0), 0, 32'sh7fff_ffff));
		send_beat(add_beat(key_of(0), 0, 32'sh0000_0001));
		send_beat(add_beat(key_of(0), KMER, 32'sh8000_0000));
		send_beat(add_beat(key_of(0), KMER, -32'sd1));
		send_beat(add_beat(key_of(0), 2, 32'sh0));
		send_beat(read_beat(key_of(0)));
		send_beat(add_beat(key_of('1), 6, 32'sd5));
		send_beat(add_beat(key_of('1), 7, -32'sd7));
		send_beat(read_beat(key_of('1)));
		send_beat(add_beat({8'h61, CHAR_C, CHAR_G, CHAR_U, CHAR_A}, 1, 32'sd9));
		send_beat(read_beat({CHAR_A, CHAR_C, 8'h54, CHAR_U, CHAR_A}));
		send_beat(add_beat('1, 0, 32'sd1));
		send_beat(read_beat('0));
		send_beat(add_beat(key_of(10'h1B4), 1, 32'sh8000_0000));
		send_beat(add_beat(key_of(10'h1B4), 1, 32'sh8000_0000));
		send_beat(add_beat(key_of(10'h1B4), 3, 32'sh7fff_ffff));
		send_beat(add_beat(key_of(10'h1B4), 3, 32'sh7fff_ffff));
		send_beat(add_beat(key_of(10'h1B4), 4, 32'sh0001_0000));
		send_beat(read_beat(key_of(10'h1B4)));
		send_beat(add_beat(key_of('1), 3, -32'sd1));
		send_beat(read_beat(key_of('1)));
		send_beat(add_beat(spoil(key_of(10'h2C7), 0), 2, 32'sd3));
		send_beat(read_beat(spoil(key_of(10'h2C7), KMER - 1)));
		drain();

		foreach (hot_keys[i])
			hot_keys[i] = IDX_W'($urandom);
		while (sent < RANDOM_BEATS + 24) begin
			quiet <= (sent >= 200 && sent < 330);
			if (sent % 120 == 0)
				drain();
			case ($urandom_range(19))
				0, 1, 2: begin
					idx = $urandom_range(3) == 0 ? IDX_W'($urandom) : hot_keys[$urandom_range(7)];
					send_beat(read_beat(key_of(idx)));
				end
				3, 4: begin
					k = $urandom_range(1) ? KEY_W'({$urandom, $urandom}) :
						spoil(key_of(IDX_W'($urandom)), $urandom_range(KMER - 1));
					if ($urandom_range(1))
						send_beat(read_beat(k));
					else
						send_beat(add_beat(k, $urandom_range(7), pick_amount()));
				end
				5: send_beat(add_beat(key_of(hot_keys[$urandom_range(7)]),
					$urandom_range(KMER + 1, 7), pick_amount()));
				default: begin
					idx = hot_keys[$urandom_range(7)];
					repeat ($urandom_range(1, 4))
						send_beat(add_beat(key_of(idx), $urandom_range(KMER), pick_amount()));
					send_beat(read_beat(key_of(idx)));
				end
			endcase
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
